>>> sv/i2cem_pkg.sv
// Types and constants shared by the I2C EEPROM master files.
`default_nettype none
package i2cem_pkg;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_POLL  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_S1    = 4'd1,
    PH_S2    = 4'd2,
    PH_S3    = 4'd3,
    PH_TXL   = 4'd4,
    PH_TXH   = 4'd5,
    PH_AL    = 4'd6,
    PH_AH    = 4'd7,
    PH_AS    = 4'd8,
    PH_RXH   = 4'd9,
    PH_RXS   = 4'd10,
    PH_NACKH = 4'd11,
    PH_P1    = 4'd12,
    PH_P2    = 4'd13,
    PH_P3    = 4'd14
  } phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NACK_RDCTL  = 3'd5;
  localparam logic [2:0] ST_STRETCH     = 3'd6;
  localparam logic [2:0] ST_STOP_FAIL   = 3'd7;

  localparam logic [1:0] IDX_CTRL   = 2'd0;
  localparam logic [1:0] IDX_ADDRHI = 2'd1;
  localparam logic [1:0] IDX_ADDRLO = 2'd2;
  localparam logic [1:0] IDX_LAST   = 2'd3;

  localparam logic [1:0] REG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] REG_STOP_WAIT  = 2'd1;
  localparam logic [1:0] REG_STOP_RETRY = 2'd2;
  localparam logic [1:0] REG_STRETCH    = 2'd3;

  localparam logic [6:0] DEV_ADDR_RST   = 7'd80;
  localparam logic [7:0] STOP_WAIT_RST  = 8'd10;
  localparam logic [3:0] STOP_RETRY_RST = 4'd4;
  localparam logic [3:0] STRETCH_RST    = 4'd3;

  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] stop_wait;
    logic [3:0] stop_retry;
    logic [3:0] stretch;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  wr_data;
    logic [7:0]  poll_tries;
    logic        scl_in;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] rd_data;
  } out_item_t;

endpackage
`default_nettype wire

>>> sv/i2cem_if.sv
// Valid/ready channel interfaces for the tick and result items.
`default_nettype none
interface i2cem_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] mem_addr;
  logic [7:0]  wr_data;
  logic [7:0]  poll_tries;
  logic        scl_in;
  logic        sda_in;

  modport source (output valid, cmd, mem_addr, wr_data, poll_tries, scl_in, sda_in,
                  input ready);
  modport sink (input valid, cmd, mem_addr, wr_data, poll_tries, scl_in, sda_in,
                output ready);
endinterface

interface i2cem_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] rd_data;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, status,
                  rd_data, input ready);
  modport sink (input valid, scl_release, sda_release, busy_res, done_res, status,
                rd_data, output ready);
endinterface
`default_nettype wire

>>> sv/i2cem_queue.sv
// Two-entry item queue with independent push and pop handshakes.
`default_nettype none
module i2cem_queue #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire T     push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output T          pop_data
);

  T           mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/i2cem_engine.sv
// Bus sequencer: steps the I2C transaction by one phase tick per item.
`default_nettype none
module i2cem_engine
  import i2cem_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           res_valid,
  input  wire logic      res_ready,
  output out_item_t      res_item
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [3:0] stop_att_r, stop_att_nxt;
  logic [7:0] polls_r, polls_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0] data_r, data_nxt;
  logic [2:0] status_r, status_nxt;
  cmd_t       kind_r, kind_nxt;

  logic       step;
  logic       o_scl, o_sda, busy, finish;
  logic [3:0] att_inc;
  logic [3:0] bit_dec;
  logic       stop_fail;
  logic       stop_timeout;
  logic [1:0] idx_inc;

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [6:0] dev,
                                          input logic [15:0] addr, input logic [7:0] data,
                                          input cmd_t kind);
    logic [7:0] b;
    unique case (idx)
      IDX_CTRL:   b = {dev, 1'b0};
      IDX_ADDRHI: b = addr[15:8];
      IDX_ADDRLO: b = addr[7:0];
      default:    b = (kind == CMD_READ) ? {dev, 1'b1} : data;
    endcase
    return b;
  endfunction

  assign step         = in_valid && res_ready;
  assign in_ready     = res_ready;
  assign res_valid    = in_valid;
  assign att_inc      = stop_att_r + 4'd1;
  assign bit_dec      = bit_cnt_r - 4'd1;
  assign idx_inc      = byte_idx_r + 2'd1;
  assign stop_fail    = (att_inc >= cfg.stop_retry);
  assign stop_timeout = (wait_r >= cfg.stop_wait);

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    wait_nxt     = wait_r;
    stop_att_nxt = stop_att_r;
    polls_nxt    = polls_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    status_nxt   = status_r;
    kind_nxt     = kind_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_item.cmd != CMD_NONE) begin
          kind_nxt     = cmd_t'(in_item.cmd);
          addr_nxt     = in_item.mem_addr;
          data_nxt     = in_item.wr_data;
          polls_nxt    = in_item.poll_tries;
          byte_idx_nxt = IDX_CTRL;
          status_nxt   = ST_OK;
          stop_att_nxt = 4'd0;
          phase_nxt    = PH_S1;
        end
      end
      PH_S1: phase_nxt = PH_S2;
      PH_S2: phase_nxt = PH_S3;
      PH_S3: begin
        shift_nxt   = byte_for(byte_idx_r, cfg.dev_addr, addr_r, data_r, kind_r);
        bit_cnt_nxt = BITS_PER_BYTE;
        phase_nxt   = PH_TXL;
      end
      PH_TXL: phase_nxt = PH_TXH;
      PH_TXH: begin
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_dec;
        phase_nxt   = (bit_dec != 4'd0) ? PH_TXL : PH_AL;
      end
      PH_AL: phase_nxt = PH_AH;
      PH_AH: phase_nxt = PH_AS;
      PH_AS: begin
        if (in_item.sda_in) begin
          if (kind_r == CMD_POLL && polls_r != 8'd0) begin
            polls_nxt = polls_r - 8'd1;
            phase_nxt = PH_S1;
          end else begin
            status_nxt   = (kind_r == CMD_READ && byte_idx_r == IDX_LAST) ? ST_NACK_RDCTL
                                                                         : {1'b0, byte_idx_r} + 3'd1;
            stop_att_nxt = 4'd0;
            phase_nxt    = PH_P1;
          end
        end else if (kind_r == CMD_WRITE && byte_idx_r != IDX_LAST) begin
          byte_idx_nxt = idx_inc;
          shift_nxt    = byte_for(idx_inc, cfg.dev_addr, addr_r, data_r, kind_r);
          bit_cnt_nxt  = BITS_PER_BYTE;
          phase_nxt    = PH_TXL;
        end else if (kind_r == CMD_READ && byte_idx_r != IDX_LAST) begin
          byte_idx_nxt = idx_inc;
          if (byte_idx_r == IDX_ADDRLO) begin
            phase_nxt = PH_S1;
          end else begin
            shift_nxt   = byte_for(idx_inc, cfg.dev_addr, addr_r, data_r, kind_r);
            bit_cnt_nxt = BITS_PER_BYTE;
            phase_nxt   = PH_TXL;
          end
        end else if (kind_r == CMD_READ) begin
          shift_nxt   = 8'd0;
          bit_cnt_nxt = BITS_PER_BYTE;
          phase_nxt   = PH_RXH;
        end else begin
          stop_att_nxt = 4'd0;
          phase_nxt    = PH_P1;
        end
      end
      PH_RXH: begin
        wait_nxt  = 8'd1;
        phase_nxt = PH_RXS;
      end
      PH_RXS: begin
        if (in_item.scl_in) begin
          shift_nxt   = {shift_r[6:0], in_item.sda_in};
          bit_cnt_nxt = bit_dec;
          phase_nxt   = (bit_dec != 4'd0) ? PH_RXH : PH_NACKH;
        end else if (wait_r >= {4'd0, cfg.stretch}) begin
          status_nxt   = ST_STRETCH;
          stop_att_nxt = 4'd0;
          phase_nxt    = PH_P1;
        end else begin
          wait_nxt = wait_r + 8'd1;
        end
      end
      PH_NACKH: begin
        stop_att_nxt = 4'd0;
        phase_nxt    = PH_P1;
      end
      PH_P1: phase_nxt = PH_P2;
      PH_P2: begin
        wait_nxt  = 8'd0;
        phase_nxt = PH_P3;
      end
      PH_P3: begin
        if (in_item.scl_in) begin
          phase_nxt = PH_IDLE;
        end else if (stop_timeout) begin
          stop_att_nxt = att_inc;
          if (stop_fail) begin
            status_nxt = ST_STOP_FAIL;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_P1;
          end
        end else begin
          wait_nxt = wait_r + 8'd1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // line and status outputs
  always_comb begin
    o_scl  = 1'b1;
    o_sda  = 1'b1;
    busy   = 1'b1;
    finish = 1'b0;
    unique case (phase_r)
      PH_IDLE: busy = (in_item.cmd != CMD_NONE);
      PH_S2:   o_sda = 1'b0;
      PH_S3: begin
        o_sda = 1'b0;
        o_scl = 1'b0;
      end
      PH_TXL: begin
        o_scl = 1'b0;
        o_sda = shift_r[7];
      end
      PH_TXH:  o_sda = shift_r[7];
      PH_AL:   o_scl = 1'b0;
      PH_AS:   o_scl = 1'b0;
      PH_RXS:  o_scl = ~in_item.scl_in;
      PH_P1: begin
        o_scl = 1'b0;
        o_sda = 1'b0;
      end
      PH_P2:   o_sda = 1'b0;
      PH_P3: begin
        if (in_item.scl_in || (stop_timeout && stop_fail)) begin
          finish = 1'b1;
        end else begin
          o_sda = 1'b0;
        end
      end
      PH_S1, PH_AH, PH_RXH, PH_NACKH: begin
        o_scl = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    res_item.scl_release = o_scl;
    res_item.sda_release = o_sda;
    res_item.busy_res    = busy && !finish;
    res_item.done_res    = finish;
    res_item.status      = status_nxt;
    res_item.rd_data     = (finish && kind_r == CMD_READ && status_nxt == ST_OK) ? shift_r
                                                                               : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      byte_idx_r <= IDX_CTRL;
      wait_r     <= 8'd0;
      stop_att_r <= 4'd0;
      polls_r    <= 8'd0;
      addr_r     <= 16'd0;
      data_r     <= 8'd0;
      status_r   <= ST_OK;
      kind_r     <= CMD_NONE;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_idx_r <= byte_idx_nxt;
      wait_r     <= wait_nxt;
      stop_att_r <= stop_att_nxt;
      polls_r    <= polls_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      status_r   <= status_nxt;
      kind_r     <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/i2c_eeprom_master.sv
// Top level of the I2C EEPROM master: register port, tick queue, sequencer, result queue.
//
// Open-drain I2C master for a two-byte-addressed EEPROM (byte write, random byte read,
// ACK polling). Every input item is one bus phase tick and yields exactly one result
// item holding the SCL/SDA releases for that tick, busy, done, status and read data.
// Items are taken one per clock while the tick queue has room: a two-entry queue holds
// incoming ticks, the sequencer steps one tick per cycle whenever the two-entry result
// queue has room, and each result is registered in that queue. Configuration registers
// (device_address, stop_wait_limit, stop_retry_limit, stretch_tries) sit at byte
// addresses 0, 4, 8 and 12 and take effect at once.
`default_nettype none
module i2c_eeprom_master
  import i2cem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  i2cem_in_if.sink         in_chan,
  i2cem_out_if.source      out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  in_item_t   in_item;
  in_item_t   head_item;
  logic       head_valid, head_ready;
  out_item_t  res_item, out_item;
  logic       res_valid, res_ready;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEV_ADDR:   cfg_nxt.dev_addr   = pwdata[6:0];
        REG_STOP_WAIT:  cfg_nxt.stop_wait  = pwdata[7:0];
        REG_STOP_RETRY: cfg_nxt.stop_retry = pwdata[3:0];
        default:        cfg_nxt.stretch    = pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEV_ADDR:   prdata = {25'd0, cfg_r.dev_addr};
      REG_STOP_WAIT:  prdata = {24'd0, cfg_r.stop_wait};
      REG_STOP_RETRY: prdata = {28'd0, cfg_r.stop_retry};
      default:        prdata = {28'd0, cfg_r.stretch};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr   <= DEV_ADDR_RST;
      cfg_r.stop_wait  <= STOP_WAIT_RST;
      cfg_r.stop_retry <= STOP_RETRY_RST;
      cfg_r.stretch    <= STRETCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    in_item.cmd        = in_chan.cmd;
    in_item.mem_addr   = in_chan.mem_addr;
    in_item.wr_data    = in_chan.wr_data;
    in_item.poll_tries = in_chan.poll_tries;
    in_item.scl_in     = in_chan.scl_in;
    in_item.sda_in     = in_chan.sda_in;
  end

  i2cem_queue #(.T(in_item_t)) u_in_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_chan.valid),
    .push_ready (in_chan.ready),
    .push_data  (in_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_item)
  );

  i2cem_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (head_valid),
    .in_ready  (head_ready),
    .in_item   (head_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  i2cem_queue #(.T(out_item_t)) u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res_item),
    .pop_valid  (out_chan.valid),
    .pop_ready  (out_chan.ready),
    .pop_data   (out_item)
  );

  assign out_chan.scl_release = out_item.scl_release;
  assign out_chan.sda_release = out_item.sda_release;
  assign out_chan.busy_res    = out_item.busy_res;
  assign out_chan.done_res    = out_item.done_res;
  assign out_chan.status      = out_item.status;
  assign out_chan.rd_data     = out_item.rd_data;

endmodule
`default_nettype wire

>>> sv/i2cem_checker.sv
// Port-level assertions for the I2C EEPROM master and their bind.
`default_nettype none
module i2cem_checker
  import i2cem_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       sda_release,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [2:0] status,
  input wire logic [7:0] rd_data
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done item still reports busy");

  a_done_releases_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> sda_release)
    else $error("done item does not release SDA");

  a_rd_only_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (rd_data != 8'd0) |-> done_res && (status == ST_OK))
    else $error("read data outside a successful done item");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_eeprom_master i2cem_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .sda_release (out_chan.sda_release),
  .busy_res    (out_chan.busy_res),
  .done_res    (out_chan.done_res),
  .status      (out_chan.status),
  .rd_data     (out_chan.rd_data)
);
`default_nettype wire
